### design/cle_pkg.sv
// Shared types and constants for the cursor list engine.
// No dependencies; imported by cle_store and cursor_list_engine.
package cle_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned LINK_W   = SLOT_W + 1;
  localparam int unsigned COUNT_W  = SLOT_W + 1;
  localparam int unsigned VALUE_W  = 32;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [VALUE_W-1:0] value_t;

  // Link with the top bit set means "no slot".
  localparam link_t NO_LINK = link_t'(CAPACITY);

  typedef enum logic [3:0] {
    MODE_QUERY     = 4'd0,
    MODE_CLEAR     = 4'd1,
    MODE_FRONT     = 4'd2,
    MODE_BACK      = 4'd3,
    MODE_PREV      = 4'd4,
    MODE_NEXT      = 4'd5,
    MODE_PREPEND   = 4'd6,
    MODE_APPEND    = 4'd7,
    MODE_INSBEFORE = 4'd8,
    MODE_INSAFTER  = 4'd9,
    MODE_DELFRONT  = 4'd10,
    MODE_DELBACK   = 4'd11,
    MODE_DELCURSOR = 4'd12,
    MODE_SET       = 4'd13
  } mode_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  // Requests into the slot store: one read and one write per memory.
  typedef struct packed {
    slot_t  nxt_raddr;
    slot_t  prv_raddr;
    slot_t  frd_raddr;
    slot_t  val_raddr;
    logic   nxt_we;
    slot_t  nxt_waddr;
    link_t  nxt_wdata;
    logic   prv_we;
    slot_t  prv_waddr;
    link_t  prv_wdata;
    logic   val_we;
    slot_t  val_waddr;
    value_t val_wdata;
    logic   frd_we;
    slot_t  frd_waddr;
    slot_t  frd_wdata;
  } store_req_t;

  // Registered read data, valid the cycle after the address.
  typedef struct packed {
    link_t  nxt_rdata;
    link_t  prv_rdata;
    slot_t  frd_rdata;
    value_t val_rdata;
  } store_rsp_t;

endpackage

### design/cle_store.sv
// Slot store: value, next-link, prev-link and freed-slot memories.
// Depends on cle_pkg. Synchronous reads, data valid the cycle after the address; no reset.
module cle_store (
  input  logic                clk_i,
  input  cle_pkg::store_req_t req_i,
  output cle_pkg::store_rsp_t rsp_o
);
  import cle_pkg::*;

  value_t val_mem [CAPACITY];
  link_t  nxt_mem [CAPACITY];
  link_t  prv_mem [CAPACITY];
  slot_t  frd_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.val_we) begin
      val_mem[req_i.val_waddr] <= req_i.val_wdata;
    end
    if (req_i.nxt_we) begin
      nxt_mem[req_i.nxt_waddr] <= req_i.nxt_wdata;
    end
    if (req_i.prv_we) begin
      prv_mem[req_i.prv_waddr] <= req_i.prv_wdata;
    end
    if (req_i.frd_we) begin
      frd_mem[req_i.frd_waddr] <= req_i.frd_wdata;
    end
    rsp_o.val_rdata <= val_mem[req_i.val_raddr];
    rsp_o.nxt_rdata <= nxt_mem[req_i.nxt_raddr];
    rsp_o.prv_rdata <= prv_mem[req_i.prv_raddr];
    rsp_o.frd_rdata <= frd_mem[req_i.frd_raddr];
  end

endmodule

### design/cursor_list_engine.sv
// Cursor list engine: bounded doubly linked list of 32-bit values with one cursor.
// Depends on cle_pkg and cle_store.
// Sequence: a word is accepted in IDLE, then EXEC and DONE follow; the result strobe is registered in DONE.
// Steps: accept, link update, value fetch / second link write. No new word is taken until DONE ends;
// busy is high in EXEC and DONE. The result cannot be stalled.
// Reset: asynchronous, active low; the list comes up empty with the cursor undefined.
module cursor_list_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [3:0]            mode_i,
  input  logic signed [31:0]    value_i,
  output logic                  result_valid_o,
  output logic [1:0]            status_o,
  output logic [8:0]            list_length_o,
  output logic signed [8:0]     cursor_index_o,
  output logic signed [31:0]    front_value_o,
  output logic signed [31:0]    back_value_o,
  output logic signed [31:0]    cursor_value_o
);
  import cle_pkg::*;

  // Sequencer: IDLE issues link/freed reads for the candidate word,
  // EXEC applies the operation, DONE fetches values and finishes inserts.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam value_t NONE_VALUE = '1;

  store_req_t req;
  store_rsp_t rsp;

  logic [1:0]        state_q, state_d;
  mode_e             mode_q, mode_d;
  value_t            value_q, value_d;
  link_t             head_q, head_d;
  link_t             tail_q, tail_d;
  link_t             cur_q, cur_d;
  logic signed [8:0] pos_q, pos_d;
  count_t            count_q, count_d;
  count_t            fresh_q, fresh_d;
  count_t            freed_q, freed_d;
  value_t            head_val_q, head_val_d;
  value_t            tail_val_q, tail_val_d;
  value_t            cur_val_q, cur_val_d;
  status_e           stat_q, stat_d;

  // pending value fetches, resolved in DONE
  logic              fill_head_q, fill_head_d;
  logic              fill_tail_q, fill_tail_d;
  logic              fill_cur_q, fill_cur_d;

  // second half of an insert: neighbor links pointing at the new slot
  logic              wr_nxt_q, wr_nxt_d;
  logic              wr_prv_q, wr_prv_d;
  link_t             wr_p_q, wr_p_d;
  link_t             wr_n_q, wr_n_d;
  slot_t             wr_s_q, wr_s_d;

  logic              out_valid_q;
  logic [1:0]        out_stat_q;
  count_t            out_len_q;
  logic signed [8:0] out_pos_q;
  value_t            out_front_q, out_back_q, out_cur_q;

  // EXEC helpers
  logic              has_cur, empty, full;
  logic              ins_en, del_en;
  link_t             ins_p, ins_n, del_p, del_n;
  slot_t             del_s, new_slot;
  link_t             mv_link;

  cle_store u_store (
    .clk_i (clk_i),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign busy    = (state_q != ST_IDLE);
  assign has_cur = !pos_q[8] && !cur_q[SLOT_W];
  assign empty   = (count_q == '0);
  assign full    = (count_q == count_t'(CAPACITY));
  assign new_slot = (freed_q != '0) ? rsp.frd_rdata : fresh_q[SLOT_W-1:0];

  always_comb begin
    req         = '0;
    state_d     = state_q;
    mode_d      = mode_q;
    value_d     = value_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cur_d       = cur_q;
    pos_d       = pos_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    freed_d     = freed_q;
    head_val_d  = head_val_q;
    tail_val_d  = tail_val_q;
    cur_val_d   = cur_val_q;
    stat_d      = stat_q;
    fill_head_d = fill_head_q;
    fill_tail_d = fill_tail_q;
    fill_cur_d  = fill_cur_q;
    wr_nxt_d    = wr_nxt_q;
    wr_prv_d    = wr_prv_q;
    wr_p_d      = wr_p_q;
    wr_n_d      = wr_n_q;
    wr_s_d      = wr_s_q;
    ins_en      = 1'b0;
    del_en      = 1'b0;
    ins_p       = NO_LINK;
    ins_n       = NO_LINK;
    del_p       = NO_LINK;
    del_n       = NO_LINK;
    del_s       = '0;
    mv_link     = NO_LINK;

    case (state_q)
      ST_IDLE: begin
        // Reads for the word being offered; data lands in EXEC.
        req.nxt_raddr = (mode_i == MODE_DELFRONT) ? head_q[SLOT_W-1:0] : cur_q[SLOT_W-1:0];
        req.prv_raddr = (mode_i == MODE_DELBACK)  ? tail_q[SLOT_W-1:0] : cur_q[SLOT_W-1:0];
        req.frd_raddr = freed_q[SLOT_W-1:0] - slot_t'(1);
        if (start) begin
          mode_d  = mode_e'(mode_i);
          value_d = value_i;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        stat_d      = STAT_DONE;
        fill_head_d = 1'b0;
        fill_tail_d = 1'b0;
        fill_cur_d  = 1'b0;
        wr_nxt_d    = 1'b0;
        wr_prv_d    = 1'b0;
        state_d     = ST_DONE;

        case (mode_q)
          MODE_QUERY: begin
          end
          MODE_CLEAR: begin
            freed_d = '0;
            fresh_d = '0;
            head_d  = NO_LINK;
            tail_d  = NO_LINK;
            cur_d   = NO_LINK;
            pos_d   = -9'sd1;
            count_d = '0;
          end
          MODE_FRONT, MODE_BACK: begin
            if (empty) begin
              stat_d = STAT_IGNORED;
            end else if (mode_q == MODE_FRONT) begin
              cur_d     = head_q;
              pos_d     = '0;
              cur_val_d = head_val_q;
            end else begin
              cur_d     = tail_q;
              pos_d     = $signed(count_q - count_t'(1));
              cur_val_d = tail_val_q;
            end
          end
          MODE_PREV, MODE_NEXT: begin
            mv_link = (mode_q == MODE_PREV) ? rsp.prv_rdata : rsp.nxt_rdata;
            if (!has_cur) begin
              stat_d = STAT_IGNORED;
            end else if (mv_link[SLOT_W]) begin
              cur_d = NO_LINK;
              pos_d = -9'sd1;
            end else begin
              cur_d         = mv_link;
              pos_d         = (mode_q == MODE_PREV) ? pos_q - 9'sd1 : pos_q + 9'sd1;
              fill_cur_d    = 1'b1;
              req.val_raddr = mv_link[SLOT_W-1:0];
            end
          end
          MODE_PREPEND: begin
            if (full) begin
              stat_d = STAT_FULL;
            end else begin
              ins_en = 1'b1;
              ins_p  = NO_LINK;
              ins_n  = head_q;
              if (has_cur) begin
                pos_d = pos_q + 9'sd1;
              end
            end
          end
          MODE_APPEND: begin
            if (full) begin
              stat_d = STAT_FULL;
            end else begin
              ins_en = 1'b1;
              ins_p  = tail_q;
              ins_n  = NO_LINK;
            end
          end
          MODE_INSBEFORE: begin
            if (!has_cur) begin
              stat_d = STAT_IGNORED;
            end else if (full) begin
              stat_d = STAT_FULL;
            end else begin
              ins_en = 1'b1;
              ins_p  = rsp.prv_rdata;
              ins_n  = cur_q;
              pos_d  = pos_q + 9'sd1;
            end
          end
          MODE_INSAFTER: begin
            if (!has_cur) begin
              stat_d = STAT_IGNORED;
            end else if (full) begin
              stat_d = STAT_FULL;
            end else begin
              ins_en = 1'b1;
              ins_p  = cur_q;
              ins_n  = rsp.nxt_rdata;
            end
          end
          MODE_DELFRONT: begin
            if (empty) begin
              stat_d = STAT_IGNORED;
            end else begin
              del_en = 1'b1;
              del_s  = head_q[SLOT_W-1:0];
              del_p  = NO_LINK;
              del_n  = rsp.nxt_rdata;
              if (has_cur && cur_q == head_q) begin
                cur_d = NO_LINK;
                pos_d = -9'sd1;
              end else if (has_cur) begin
                pos_d = pos_q - 9'sd1;
              end
            end
          end
          MODE_DELBACK: begin
            if (empty) begin
              stat_d = STAT_IGNORED;
            end else begin
              del_en = 1'b1;
              del_s  = tail_q[SLOT_W-1:0];
              del_p  = rsp.prv_rdata;
              del_n  = NO_LINK;
              if (has_cur && cur_q == tail_q) begin
                cur_d = NO_LINK;
                pos_d = -9'sd1;
              end
            end
          end
          MODE_DELCURSOR: begin
            if (!has_cur) begin
              stat_d = STAT_IGNORED;
            end else begin
              del_en = 1'b1;
              del_s  = cur_q[SLOT_W-1:0];
              del_p  = rsp.prv_rdata;
              del_n  = rsp.nxt_rdata;
              cur_d  = NO_LINK;
              pos_d  = -9'sd1;
            end
          end
          MODE_SET: begin
            if (!has_cur) begin
              stat_d = STAT_IGNORED;
            end else begin
              req.val_we    = 1'b1;
              req.val_waddr = cur_q[SLOT_W-1:0];
              req.val_wdata = value_q;
              cur_val_d     = value_q;
              if (cur_q == head_q) begin
                head_val_d = value_q;
              end
              if (cur_q == tail_q) begin
                tail_val_d = value_q;
              end
            end
          end
          default: begin
            stat_d = STAT_IGNORED;
          end
        endcase

        // Link in a new slot: own entries now, neighbor entries in DONE.
        if (ins_en) begin
          if (freed_q != '0) begin
            freed_d = freed_q - count_t'(1);
          end else begin
            fresh_d = fresh_q + count_t'(1);
          end
          req.val_we    = 1'b1;
          req.val_waddr = new_slot;
          req.val_wdata = value_q;
          req.nxt_we    = 1'b1;
          req.nxt_waddr = new_slot;
          req.nxt_wdata = ins_n;
          req.prv_we    = 1'b1;
          req.prv_waddr = new_slot;
          req.prv_wdata = ins_p;
          wr_s_d        = new_slot;
          wr_p_d        = ins_p;
          wr_n_d        = ins_n;
          wr_nxt_d      = !ins_p[SLOT_W];
          wr_prv_d      = !ins_n[SLOT_W];
          if (ins_p[SLOT_W]) begin
            head_d     = {1'b0, new_slot};
            head_val_d = value_q;
          end
          if (ins_n[SLOT_W]) begin
            tail_d     = {1'b0, new_slot};
            tail_val_d = value_q;
          end
          count_d = count_q + count_t'(1);
        end

        // Unlink a slot and push it on the freed stack.
        if (del_en) begin
          if (!del_p[SLOT_W]) begin
            req.nxt_we    = 1'b1;
            req.nxt_waddr = del_p[SLOT_W-1:0];
            req.nxt_wdata = del_n;
          end else begin
            head_d = del_n;
          end
          if (!del_n[SLOT_W]) begin
            req.prv_we    = 1'b1;
            req.prv_waddr = del_n[SLOT_W-1:0];
            req.prv_wdata = del_p;
          end else begin
            tail_d = del_p;
          end
          if (freed_q != count_t'(CAPACITY)) begin
            req.frd_we    = 1'b1;
            req.frd_waddr = freed_q[SLOT_W-1:0];
            req.frd_wdata = del_s;
            freed_d       = freed_q + count_t'(1);
          end
          // new end element needs its value fetched
          if (del_p[SLOT_W] && !del_n[SLOT_W]) begin
            fill_head_d   = 1'b1;
            req.val_raddr = del_n[SLOT_W-1:0];
          end else if (del_n[SLOT_W] && !del_p[SLOT_W]) begin
            fill_tail_d   = 1'b1;
            req.val_raddr = del_p[SLOT_W-1:0];
          end
          count_d = count_q - count_t'(1);
        end
      end

      ST_DONE: begin
        if (wr_nxt_q) begin
          req.nxt_we    = 1'b1;
          req.nxt_waddr = wr_p_q[SLOT_W-1:0];
          req.nxt_wdata = {1'b0, wr_s_q};
        end
        if (wr_prv_q) begin
          req.prv_we    = 1'b1;
          req.prv_waddr = wr_n_q[SLOT_W-1:0];
          req.prv_wdata = {1'b0, wr_s_q};
        end
        if (fill_head_q) begin
          head_val_d = rsp.val_rdata;
        end
        if (fill_tail_q) begin
          tail_val_d = rsp.val_rdata;
        end
        if (fill_cur_q) begin
          cur_val_d = rsp.val_rdata;
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_QUERY;
      head_q      <= NO_LINK;
      tail_q      <= NO_LINK;
      cur_q       <= NO_LINK;
      pos_q       <= -9'sd1;
      count_q     <= '0;
      fresh_q     <= '0;
      freed_q     <= '0;
      stat_q      <= STAT_DONE;
      fill_head_q <= 1'b0;
      fill_tail_q <= 1'b0;
      fill_cur_q  <= 1'b0;
      wr_nxt_q    <= 1'b0;
      wr_prv_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cur_q       <= cur_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      freed_q     <= freed_d;
      stat_q      <= stat_d;
      fill_head_q <= fill_head_d;
      fill_tail_q <= fill_tail_d;
      fill_cur_q  <= fill_cur_d;
      wr_nxt_q    <= wr_nxt_d;
      wr_prv_q    <= wr_prv_d;
      out_valid_q <= (state_q == ST_DONE);
    end
  end

  // Payload registers: operand, end values, pending link targets, result word.
  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    head_val_q <= head_val_d;
    tail_val_q <= tail_val_d;
    cur_val_q  <= cur_val_d;
    wr_p_q     <= wr_p_d;
    wr_n_q     <= wr_n_d;
    wr_s_q     <= wr_s_d;
    if (state_q == ST_DONE) begin
      out_stat_q  <= stat_q;
      out_len_q   <= count_q;
      out_pos_q   <= pos_q;
      out_front_q <= empty ? NONE_VALUE : head_val_d;
      out_back_q  <= empty ? NONE_VALUE : tail_val_d;
      out_cur_q   <= has_cur ? cur_val_d : NONE_VALUE;
    end
  end

  assign result_valid_o = out_valid_q;
  assign status_o       = out_stat_q;
  assign list_length_o  = out_len_q;
  assign cursor_index_o = out_pos_q;
  assign front_value_o  = $signed(out_front_q);
  assign back_value_o   = $signed(out_back_q);
  assign cursor_value_o = $signed(out_cur_q);

endmodule

### bench/tb.sv
// Self-checking bench for cursor_list_engine: a scoreboard class mirrors the list and
// cursor, and every result strobe is checked against it. Needs cle_pkg and the design.
import cle_pkg::*;

// One result word as seen on the output ports.
typedef struct packed {
  logic [1:0]         status;
  count_t             length;
  logic signed [8:0]  cursor_index;
  value_t             front;
  value_t             back;
  value_t             cursor_val;
} list_view_t;

class cursor_list_scoreboard;
  // Mirror of the slot memories and pointers.
  value_t      vals  [CAPACITY];
  link_t       fwd   [CAPACITY];
  link_t       bwd   [CAPACITY];
  slot_t       freed [CAPACITY];
  int unsigned n_freed, n_fresh, len;
  link_t       head, tail, cur;
  int          cur_pos;
  list_view_t  pending_views[$];
  int          fails;

  function new();
    fails = 0;
    empty_list();
  endfunction

  function void drop_cursor();
    cur     = NO_LINK;
    cur_pos = -1;
  endfunction

  function void empty_list();
    n_freed = 0;
    n_fresh = 0;
    head    = NO_LINK;
    tail    = NO_LINK;
    len     = 0;
    drop_cursor();
  endfunction

  function bit has_cursor();
    return cur_pos >= 0 && cur < NO_LINK;
  endfunction

  // Freed slots are reused last-in first-out, otherwise the next fresh slot.
  function link_t take_slot();
    if (n_freed > 0) begin
      n_freed--;
      return link_t'(freed[n_freed[SLOT_W-1:0]]);
    end
    n_fresh++;
    return link_t'((n_fresh - 1) % CAPACITY);
  endfunction

  function void link_in(link_t s, link_t p, link_t n, value_t v);
    vals[s[SLOT_W-1:0]] = v;
    bwd[s[SLOT_W-1:0]]  = p;
    fwd[s[SLOT_W-1:0]]  = n;
    if (p < NO_LINK) fwd[p[SLOT_W-1:0]] = s; else head = s;
    if (n < NO_LINK) bwd[n[SLOT_W-1:0]] = s; else tail = s;
    len++;
  endfunction

  function void unlink(link_t s);
    link_t p, n;
    p = bwd[s[SLOT_W-1:0]];
    n = fwd[s[SLOT_W-1:0]];
    if (p < NO_LINK) fwd[p[SLOT_W-1:0]] = n; else head = n;
    if (n < NO_LINK) bwd[n[SLOT_W-1:0]] = p; else tail = p;
    if (n_freed < CAPACITY) begin
      freed[n_freed[SLOT_W-1:0]] = s[SLOT_W-1:0];
      n_freed++;
    end
    len--;
  endfunction

  function list_view_t apply_word(logic [3:0] mode, value_t v);
    list_view_t r;
    logic [1:0] st;
    link_t      s;
    bit         cur_ok;
    bit         at_cap;
    st     = STAT_DONE;
    cur_ok = has_cursor();
    at_cap = (len >= CAPACITY);
    case (mode)
      MODE_QUERY: ;
      MODE_CLEAR: empty_list();
      MODE_FRONT, MODE_BACK: begin
        if (len == 0) st = STAT_IGNORED;
        else if (mode == MODE_FRONT) begin
          cur     = head;
          cur_pos = 0;
        end else begin
          cur     = tail;
          cur_pos = len - 1;
        end
      end
      MODE_PREV, MODE_NEXT: begin
        if (!cur_ok) st = STAT_IGNORED;
        else begin
          cur = (mode == MODE_PREV) ? bwd[cur[SLOT_W-1:0]] : fwd[cur[SLOT_W-1:0]];
          // stepping off either end leaves the cursor undefined
          if (cur >= NO_LINK) drop_cursor();
          else cur_pos += (mode == MODE_PREV) ? -1 : 1;
        end
      end
      MODE_PREPEND: begin
        if (at_cap) st = STAT_FULL;
        else begin
          link_in(take_slot(), NO_LINK, head, v);
          if (cur_ok) cur_pos++;
        end
      end
      MODE_APPEND: begin
        if (at_cap) st = STAT_FULL;
        else link_in(take_slot(), tail, NO_LINK, v);
      end
      MODE_INSBEFORE: begin
        // undefined cursor wins over a full list
        if (!cur_ok) st = STAT_IGNORED;
        else if (at_cap) st = STAT_FULL;
        else begin
          link_in(take_slot(), bwd[cur[SLOT_W-1:0]], cur, v);
          cur_pos++;
        end
      end
      MODE_INSAFTER: begin
        if (!cur_ok) st = STAT_IGNORED;
        else if (at_cap) st = STAT_FULL;
        else link_in(take_slot(), cur, fwd[cur[SLOT_W-1:0]], v);
      end
      MODE_DELFRONT: begin
        if (len == 0) st = STAT_IGNORED;
        else begin
          s = head;
          if (cur_ok && cur == s) drop_cursor();
          else if (cur_ok) cur_pos--;
          unlink(s);
        end
      end
      MODE_DELBACK: begin
        if (len == 0) st = STAT_IGNORED;
        else begin
          s = tail;
          if (cur_ok && cur == s) drop_cursor();
          unlink(s);
        end
      end
      MODE_DELCURSOR: begin
        if (!cur_ok) st = STAT_IGNORED;
        else begin
          s = cur;
          drop_cursor();
          unlink(s);
        end
      end
      MODE_SET: begin
        if (!cur_ok) st = STAT_IGNORED;
        else vals[cur[SLOT_W-1:0]] = v;
      end
      default: st = STAT_IGNORED;
    endcase
    r.status       = st;
    r.length       = count_t'(len);
    r.cursor_index = cur_pos[8:0];
    r.front        = (len > 0 && head < NO_LINK) ? vals[head[SLOT_W-1:0]] : '1;
    r.back         = (len > 0 && tail < NO_LINK) ? vals[tail[SLOT_W-1:0]] : '1;
    r.cursor_val   = has_cursor() ? vals[cur[SLOT_W-1:0]] : '1;
    return r;
  endfunction

  function void note_word(logic [3:0] mode, value_t v);
    pending_views.push_back(apply_word(mode, v));
  endfunction

  function int pending();
    return pending_views.size();
  endfunction

  function string view_text(list_view_t w);
    return $sformatf("status %0d len %0d cur %0d front %h back %h curval %h",
                     w.status, w.length, w.cursor_index, w.front, w.back, w.cursor_val);
  endfunction

  function void check_result(list_view_t got);
    list_view_t want;
    bit         bad;
    if (pending_views.size() == 0) begin
      fails++;
      if (fails <= 10) $display("ERROR: result word with none expected: %s", view_text(got));
      return;
    end
    want = pending_views.pop_front();
    bad  = (got.status !== want.status) || (got.length !== want.length) ||
           (got.cursor_index !== want.cursor_index) || (got.front !== want.front) ||
           (got.back !== want.back) || (got.cursor_val !== want.cursor_val);
    if (bad) begin
      fails++;
      if (fails <= 10) begin
        $display("ERROR: result mismatch");
        $display("  expected %s", view_text(want));
        $display("  actual   %s", view_text(got));
      end
    end
  endfunction
endclass

module tb;

  // Modes past the decoded range; the block must ignore them.
  localparam logic [3:0] MODE_SPARE_LO = 4'd14;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;

  localparam int ITEM_GOAL   = 1600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 8;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [3:0]         mode_i;
  logic signed [31:0] value_i;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic [8:0]         list_length_o;
  logic signed [8:0]  cursor_index_o;
  logic signed [31:0] front_value_o;
  logic signed [31:0] back_value_o;
  logic signed [31:0] cursor_value_o;

  cursor_list_scoreboard sb;
  int items_sent;
  int cycles = 0;
  bit gaps_on;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  cursor_list_engine u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .list_length_o  (list_length_o),
    .cursor_index_o (cursor_index_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o),
    .cursor_value_o (cursor_value_o)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result words cannot be held off; sample each strobe at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result({status_o, list_length_o, cursor_index_o,
                       front_value_o, back_value_o, cursor_value_o});
    end
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random values, with the corner values mixed in often.
  function value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Present one word and hold it until the block takes it (start high, busy low).
  task send_word(input logic [3:0] m, input value_t v);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    mode_i <= m;
    value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_word(m, v);
    items_sent++;
  endtask

  // Stop sending and let every outstanding result come back.
  task wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task run_mixed(input int n);
    int r;
    logic [3:0] m;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if      (r < 14) m = MODE_APPEND;
      else if (r < 24) m = MODE_PREPEND;
      else if (r < 36) m = MODE_INSBEFORE;
      else if (r < 48) m = MODE_INSAFTER;
      else if (r < 56) m = MODE_FRONT;
      else if (r < 62) m = MODE_BACK;
      else if (r < 70) m = MODE_NEXT;
      else if (r < 76) m = MODE_PREV;
      else if (r < 81) m = MODE_DELFRONT;
      else if (r < 86) m = MODE_DELBACK;
      else if (r < 91) m = MODE_DELCURSOR;
      else if (r < 95) m = MODE_SET;
      else if (r < 97) m = MODE_QUERY;
      else if (r < 98) m = MODE_CLEAR;
      else             m = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
      send_word(m, pick_value());
    end
  endtask

  // Grow the list to capacity with random inserts, then push against the limit.
  task run_fill();
    logic [3:0] m;
    while (sb.len < CAPACITY) begin
      if (!sb.has_cursor() && $urandom_range(0, 3) == 0) begin
        send_word($urandom_range(0, 1) ? MODE_FRONT : MODE_BACK, pick_value());
      end else begin
        case ($urandom_range(0, 3))
          0:       m = MODE_PREPEND;
          1:       m = MODE_APPEND;
          2:       m = MODE_INSBEFORE;
          default: m = MODE_INSAFTER;
        endcase
        send_word(m, pick_value());
      end
    end
    // full list: every insert is refused, cursor at the last index
    send_word(MODE_BACK, pick_value());
    send_word(MODE_INSBEFORE, pick_value());
    send_word(MODE_INSAFTER, pick_value());
    send_word(MODE_PREPEND, pick_value());
    send_word(MODE_APPEND, pick_value());
    send_word(MODE_PREV, pick_value());
    send_word(MODE_SET, pick_value());
    send_word(MODE_NEXT, pick_value());
  endtask

  // Empty the list through all three deletes, with cursor moves in between.
  task run_drain();
    int r;
    while (sb.len > 0) begin
      r = $urandom_range(0, 9);
      if (r < 3)      send_word(MODE_DELFRONT, pick_value());
      else if (r < 6) send_word(MODE_DELBACK, pick_value());
      else if (r < 8) begin
        if (sb.has_cursor()) send_word(MODE_DELCURSOR, pick_value());
        else send_word($urandom_range(0, 1) ? MODE_FRONT : MODE_BACK, pick_value());
      end
      else if (r == 8) send_word(MODE_NEXT, pick_value());
      else             send_word(MODE_PREV, pick_value());
    end
    send_word(MODE_DELFRONT, pick_value());
    send_word(MODE_DELBACK, pick_value());
  endtask

  initial begin
    int blk;
    sb         = new();
    items_sent = 0;
    gaps_on    = 1'b0;
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    mode_i  <= MODE_QUERY;
    value_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: operations on an empty list, then the cursor edge cases.
    send_word(MODE_QUERY, '0);
    send_word(MODE_FRONT, '0);              // empty list
    send_word(MODE_PREV, '0);               // no cursor
    send_word(MODE_INSBEFORE, 32'h5);       // no cursor
    send_word(MODE_INSAFTER, 32'h5);
    send_word(MODE_DELFRONT, '0);           // empty list
    send_word(MODE_DELBACK, '0);
    send_word(MODE_DELCURSOR, '0);
    send_word(MODE_SET, 32'h1);
    send_word(MODE_SPARE_LO, '1);
    send_word(MODE_SPARE_HI, '1);
    send_word(MODE_PREPEND, 32'h7fff_ffff); // no cursor, so no index shift
    send_word(MODE_APPEND, 32'h8000_0000);
    send_word(MODE_FRONT, '0);
    send_word(MODE_PREPEND, '0);            // cursor index shifts to 1
    send_word(MODE_PREV, '0);
    send_word(MODE_PREV, '0);               // off the front
    send_word(MODE_BACK, '0);
    send_word(MODE_NEXT, '0);               // off the back
    send_word(MODE_BACK, '0);
    send_word(MODE_INSBEFORE, '1);
    send_word(MODE_INSAFTER, 32'h5555_5555);
    send_word(MODE_SET, 32'haaaa_aaaa);
    send_word(MODE_DELFRONT, '0);           // cursor elsewhere, index drops
    send_word(MODE_DELBACK, '0);
    send_word(MODE_DELBACK, '0);            // removes the cursor element
    send_word(MODE_FRONT, '0);
    send_word(MODE_DELFRONT, '0);           // removes the cursor element
    send_word(MODE_CLEAR, '0);
    wait_idle();

    // Random: mixed traffic with fill-to-full and drain-to-empty passes.
    blk = 0;
    while (items_sent < ITEM_GOAL) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case (blk % 5)
        1:       run_fill();
        3:       run_drain();
        default: run_mixed($urandom_range(20, 80));
      endcase
      if ($urandom_range(0, 3) == 0) wait_idle();
      blk++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
